### rtl/lfp_pkg.sv
// Package for the lidar frame parser: parse phase type and header constants.
package lfp_pkg;

    // Parse phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_INFO = 3'b010,
        PH_DATA = 3'b100
    } parse_phase_t;

    // Triple position, one-hot
    typedef enum logic [2:0] {
        BP_TAG  = 3'b001,
        BP_HIGH = 3'b010,
        BP_LOW  = 3'b100
    } byte_phase_t;

    // Info byte position codes
    localparam logic [7:0] INFO_SENSOR = 8'd0;
    localparam logic [7:0] INFO_ZONES  = 8'd1;

    localparam logic [7:0] HEAD_MARK      = 8'hFF;
    localparam logic [7:0] HEAD_RUN_LIMIT = 8'd5;

endpackage

### rtl/lidar_frame_parser_core.sv
// Byte-serial lidar frame parser: header hunt, frame info, measurement triples.
// Path: a byte is taken into an input register, then parsed combinationally into the
// result register, so a triple's result follows its last byte through both registers.
// Throughput: one byte per cycle unless stalled, set by the single parse stage in between.
// Reset: rst_n (async, active low) returns to the header hunt with cleared counters,
// frame info and partial triple; both pipeline registers come up empty.
module lidar_frame_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // measurement output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  sensor_id,
    output logic [7:0]  zone_count,
    output logic [7:0]  measure_index,
    output logic [7:0]  zone_tag,
    output logic [15:0] distance,
    output logic        last
);

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    lfp_pkg::parse_phase_t phase_reg, phase_next;
    lfp_pkg::byte_phase_t  bphase_reg, bphase_next;
    logic [7:0] run_reg, run_next;
    logic [7:0] sensor_reg, sensor_next;
    logic [7:0] zones_reg, zones_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] tag_reg, tag_next;
    logic [7:0] high_reg, high_next;

    // Result register
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  res_sensor_reg, res_zones_reg, res_index_reg, res_tag_reg;
    logic [15:0] res_dist_reg;
    logic        res_last_reg;
    logic        emit;
    logic [7:0]  run_inc;
    logic        run_done;

    // Stage moves when the result slot is free or being taken
    logic advance;
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;

    assign run_inc = run_reg + 8'd1;

    // Parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        bphase_next = bphase_reg;
        run_next    = run_reg;
        sensor_next = sensor_reg;
        zones_next  = zones_reg;
        total_next  = total_reg;
        tag_next    = tag_reg;
        high_next   = high_reg;
        emit        = 1'b0;
        run_done    = ({1'b0, run_reg} + 9'd1) == {1'b0, total_reg};
        case (phase_reg)
            lfp_pkg::PH_INFO:
            begin
                if (run_reg == lfp_pkg::INFO_SENSOR)
                begin
                    sensor_next = in_byte_reg;
                    run_next    = run_inc;
                end
                else if (run_reg == lfp_pkg::INFO_ZONES)
                begin
                    zones_next = in_byte_reg;
                    run_next   = run_inc;
                end
                else
                begin
                    total_next  = in_byte_reg;
                    run_next    = 8'd0;
                    bphase_next = lfp_pkg::BP_TAG;
                    phase_next  = lfp_pkg::PH_DATA;
                end
            end
            lfp_pkg::PH_DATA:
            begin
                if (run_reg < total_reg)
                begin
                    case (bphase_reg)
                        lfp_pkg::BP_TAG:
                        begin
                            tag_next    = in_byte_reg;
                            bphase_next = lfp_pkg::BP_HIGH;
                        end
                        lfp_pkg::BP_HIGH:
                        begin
                            high_next   = in_byte_reg;
                            bphase_next = lfp_pkg::BP_LOW;
                        end
                        default:
                        begin
                            emit        = 1'b1;
                            bphase_next = lfp_pkg::BP_TAG;
                            run_next    = run_inc;
                            // final triple closes the frame
                            if (run_done)
                            begin
                                run_next   = 8'd0;
                                phase_next = lfp_pkg::PH_HUNT;
                            end
                        end
                    endcase
                end
                else
                begin
                    // zero measurement count: swallow this byte
                    run_next    = 8'd0;
                    bphase_next = lfp_pkg::BP_TAG;
                    phase_next  = lfp_pkg::PH_HUNT;
                end
            end
            default:
            begin
                // header hunt: count a run of marker bytes
                if (in_byte_reg == lfp_pkg::HEAD_MARK)
                begin
                    if (run_reg >= lfp_pkg::HEAD_RUN_LIMIT)
                    begin
                        run_next   = 8'd0;
                        phase_next = lfp_pkg::PH_INFO;
                    end
                    else
                    begin
                        run_next = run_inc;
                    end
                end
                else
                begin
                    run_next = 8'd0;
                end
            end
        endcase
    end

    assign out_vld_next = in_vld_reg && emit;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= lfp_pkg::PH_HUNT;
            bphase_reg  <= lfp_pkg::BP_TAG;
            run_reg     <= 8'd0;
            sensor_reg  <= 8'd0;
            zones_reg   <= 8'd0;
            total_reg   <= 8'd0;
            tag_reg     <= 8'd0;
            high_reg    <= 8'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= out_vld_next;
                if (in_vld_reg)
                begin
                    phase_reg  <= phase_next;
                    bphase_reg <= bphase_next;
                    run_reg    <= run_next;
                    sensor_reg <= sensor_next;
                    zones_reg  <= zones_next;
                    total_reg  <= total_next;
                    tag_reg    <= tag_next;
                    high_reg   <= high_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && out_vld_next)
        begin
            res_sensor_reg <= sensor_reg;
            res_zones_reg  <= zones_reg;
            res_index_reg  <= run_reg;
            res_tag_reg    <= tag_reg;
            res_dist_reg   <= {high_reg, in_byte_reg};
            res_last_reg   <= run_done;
        end
    end

    assign out_valid     = out_vld_reg;
    assign sensor_id     = res_sensor_reg;
    assign zone_count    = res_zones_reg;
    assign measure_index = res_index_reg;
    assign zone_tag      = res_tag_reg;
    assign distance      = res_dist_reg;
    assign last          = res_last_reg;

endmodule
